### src/slu_pkg.sv
// Shared definitions of the stack and locals unit: field widths, operation
// kinds, error codes, sequencer states and parameter defaults.
// No dependencies; stack_locals_unit and the testbench import this package.
`default_nettype none

package slu_pkg;

  // Widths of the request and result fields.
  localparam int KIND_W      = 3;
  localparam int SLOT_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int VALUE_W     = 32;
  localparam int DEPTH_OUT_W = 9;
  localparam int ERR_W       = 2;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF  = 256;
  localparam int LOCALS_DEPTH_DEF = 256;
  localparam int WORD_WIDTH_DEF   = 32;

  // Operation kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COPY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FETCH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STORE = 3'd5;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_SLOT  = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_COPY,
    S_ZERO,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### src/slu_ram.sv
// Simple dual-port word memory: one write port and one registered read port.
// Depends on nothing; used for both the data stack and the locals store.
`default_nettype none

module slu_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/stack_locals_unit.sv
// Stack and locals unit of a stack machine: data stack, depth pointer,
// locals store and the sequencer that runs the six operations.
// Depends on slu_pkg and slu_ram.
//
// Usage: a request on the in_ channel (valid/ready) carries a kind, a slot,
// a count and a push value. Each request produces exactly one result on the
// out_ channel (valid/ready): the value read, the stack depth after the
// operation and an error code. A refused operation changes no state.
// Sequence: push and every refused or empty operation go straight to the
// result; pop, fetch and store do one registered memory read, then the
// update; locals copy does one stack read and one locals write per slot,
// overlapped, and locals zero does one locals write per slot. The result is
// then presented from registers until taken; one request is in flight at a
// time, so in_ready is low from acceptance until the result is taken. A
// stalled receiver holds the unit in that state.
// Reset clears the stack depth and the sequencer; the memory contents are
// not cleared and need no clearing pass.
`default_nettype none

module stack_locals_unit import slu_pkg::*; #(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int LOCALS_DEPTH = LOCALS_DEPTH_DEF,
  parameter int WORD_WIDTH   = WORD_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic [SLOT_W-1:0]         in_slot,
  input  wire logic [COUNT_W-1:0]        in_count,
  input  wire logic signed [VALUE_W-1:0] in_push_value,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [VALUE_W-1:0] out_read_value,
  output      logic [DEPTH_OUT_W-1:0]    out_depth,
  output      logic [ERR_W-1:0]          out_error_code
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOCALS_DEPTH);

  state_t                 state_r, state_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [LAW-1:0]         cur_slot_r, cur_slot_nxt;
  logic [COUNT_W-1:0]     rem_r, rem_nxt;
  logic [WORD_WIDTH-1:0]  value_r, value_nxt;
  logic [ERR_W-1:0]       err_r, err_nxt;

  logic [ERR_W-1:0]       err_c;
  logic                   range_bad;
  logic                   accept;
  logic [DW-1:0]          depth_m1, depth_m2;

  logic                   stk_we;
  logic [SAW-1:0]         stk_waddr, stk_raddr;
  logic [WORD_WIDTH-1:0]  stk_wdata, stk_q;
  logic                   loc_we;
  logic [LAW-1:0]         loc_waddr, loc_raddr;
  logic [WORD_WIDTH-1:0]  loc_wdata, loc_q;

  assign accept   = in_valid && in_ready;
  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);

  // Data stack and locals store.
  slu_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_WIDTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  slu_ram #(.DEPTH(LOCALS_DEPTH), .WIDTH(WORD_WIDTH)) u_locals (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .raddr (loc_raddr),
    .rdata (loc_q)
  );

  // Slot range check for copy and zero: the block of count slots ending at
  // slot must lie inside the store.
  always_comb begin
    range_bad = (in_count != '0) &&
                ((32'(in_slot) >= LOCALS_DEPTH) ||
                 (32'(in_count) > 32'(in_slot) + 32'd1));
  end

  // Error check on the incoming request; stack errors win over slot errors.
  always_comb begin
    err_c = ERR_OK;
    case (in_kind)
      KIND_PUSH: begin
        if (32'(depth_r) >= STACK_DEPTH) err_c = ERR_OVER;
      end
      KIND_POP: begin
        if (depth_r == '0) err_c = ERR_UNDER;
      end
      KIND_COPY: begin
        if (32'(depth_r) < 32'(in_count)) err_c = ERR_UNDER;
        else if (range_bad)               err_c = ERR_SLOT;
      end
      KIND_ZERO: begin
        if (range_bad) err_c = ERR_SLOT;
      end
      KIND_FETCH: begin
        if (32'(depth_r) >= STACK_DEPTH)          err_c = ERR_OVER;
        else if (32'(in_slot) >= LOCALS_DEPTH)    err_c = ERR_SLOT;
      end
      KIND_STORE: begin
        if (depth_r == '0)                        err_c = ERR_UNDER;
        else if (32'(in_slot) >= LOCALS_DEPTH)    err_c = ERR_SLOT;
      end
      default: err_c = ERR_OK;
    endcase
  end

  // Sequencer: next state, memory ports and register updates.
  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    kind_nxt     = kind_r;
    cur_slot_nxt = cur_slot_r;
    rem_nxt      = rem_r;
    value_nxt    = value_r;
    err_nxt      = err_r;

    stk_we    = 1'b0;
    stk_waddr = depth_r[SAW-1:0];
    stk_wdata = loc_q;
    stk_raddr = (state_r == S_COPY) ? depth_m2[SAW-1:0] : depth_m1[SAW-1:0];
    loc_we    = 1'b0;
    loc_waddr = cur_slot_r;
    loc_wdata = stk_q;
    loc_raddr = (state_r == S_IDLE) ? LAW'(in_slot) : cur_slot_r;

    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_DONE);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt     = in_kind;
          cur_slot_nxt = LAW'(in_slot);
          rem_nxt      = in_count;
          value_nxt    = '0;
          err_nxt      = err_c;
          state_nxt    = S_DONE;
          if (err_c == ERR_OK) begin
            case (in_kind)
              KIND_PUSH: begin
                stk_we    = 1'b1;
                stk_wdata = WORD_WIDTH'(in_push_value);
                depth_nxt = depth_r + DW'(1);
              end
              KIND_POP, KIND_FETCH, KIND_STORE: begin
                state_nxt = S_RD;
              end
              KIND_COPY: begin
                if (in_count != '0) state_nxt = S_COPY;
              end
              KIND_ZERO: begin
                if (in_count != '0) state_nxt = S_ZERO;
              end
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end

      // Read data is back; finish pop, fetch or store.
      S_RD: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_POP: begin
            value_nxt = stk_q;
            depth_nxt = depth_m1;
          end
          KIND_FETCH: begin
            value_nxt = loc_q;
            stk_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
          KIND_STORE: begin
            value_nxt = stk_q;
            loc_we    = 1'b1;
            depth_nxt = depth_m1;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // Move the top of stack into the current slot while the next read runs.
      S_COPY: begin
        loc_we       = 1'b1;
        depth_nxt    = depth_m1;
        cur_slot_nxt = cur_slot_r - LAW'(1);
        rem_nxt      = rem_r - COUNT_W'(1);
        if (rem_r == COUNT_W'(1)) state_nxt = S_DONE;
      end

      // Clear one slot per cycle, walking downward.
      S_ZERO: begin
        loc_we       = 1'b1;
        loc_wdata    = '0;
        cur_slot_nxt = cur_slot_r - LAW'(1);
        rem_nxt      = rem_r - COUNT_W'(1);
        if (rem_r == COUNT_W'(1)) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    cur_slot_r <= cur_slot_nxt;
    rem_r      <= rem_nxt;
    value_r    <= value_nxt;
    err_r      <= err_nxt;
  end

  // Result fields.
  assign out_read_value = VALUE_W'(value_r);
  assign out_depth      = DEPTH_OUT_W'(depth_r);
  assign out_error_code = err_r;

  // The unit holds one request at a time.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  // The depth pointer never passes the stack size.
  assert property (@(posedge clk) disable iff (!rst_n) 32'(depth_r) <= STACK_DEPTH)
    else $error("stack depth beyond stack size");

  // A refused request leaves the depth unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (err_c != ERR_OK)) |=> (depth_r == $past(depth_r)))
    else $error("refused request changed the stack depth");

  // A walk over slots always has slots left to do.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_COPY) || (state_r == S_ZERO)) |-> (rem_r != '0))
    else $error("slot walk with no slots remaining");

  // A refused request returns a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != ERR_OK)) |-> (out_read_value == '0))
    else $error("error result with nonzero value");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for stack_locals_unit: directed corner requests, then
// random fill/drain/mixed walks, checked against an in-bench stack and locals ledger.
// Depends on slu_pkg and the stack_locals_unit RTL.
`timescale 1ns / 100ps

module tb;
  import slu_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_FROM    = 1500;   // no idling on either side from here on
  localparam int LONG_HOLD    = 400;    // long receiver hold-off, in cycles
  localparam int STALL_LIMIT  = 4000;   // cycles without any handshake
  localparam int DRAIN_CYCLES = 300;    // extra wait for stray results

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} walk_mode_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [DEPTH_OUT_W-1:0]    depth;
    logic [ERR_W-1:0]          error_code;
  } slu_result_t;

  // Shadow copy of the data stack and locals frame; queues the result each
  // accepted request should produce and checks results in order.
  class stack_frame_ledger;
    logic signed [VALUE_W-1:0] stack_words[STACK_DEPTH_DEF];
    logic signed [VALUE_W-1:0] local_words[LOCALS_DEPTH_DEF];
    bit                        local_written[LOCALS_DEPTH_DEF];
    int unsigned               depth;
    slu_result_t               results_due[$];
    int unsigned               mismatches;
    int unsigned               failures;

    function bit frame_out_of_range(int unsigned top, int unsigned n);
      return n != 0 && (top >= LOCALS_DEPTH_DEF || n > top + 1);
    endfunction

    function void apply_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                logic [COUNT_W-1:0] count,
                                logic signed [VALUE_W-1:0] push_value);
      slu_result_t r;
      int unsigned top;
      int unsigned n;
      top = 32'(slot);
      n = 32'(count);
      r.read_value = '0;
      r.error_code = ERR_OK;
      case (kind)
        KIND_PUSH: begin
          if (depth >= STACK_DEPTH_DEF) r.error_code = ERR_OVER;
          else begin
            stack_words[depth] = push_value;
            depth++;
          end
        end
        KIND_POP: begin
          if (depth == 0) r.error_code = ERR_UNDER;
          else begin
            depth--;
            r.read_value = stack_words[depth];
          end
        end
        KIND_COPY: begin
          if (depth < n) r.error_code = ERR_UNDER;
          else if (frame_out_of_range(top, n)) r.error_code = ERR_SLOT;
          else begin
            // Top of stack lands in the highest slot, walking downward.
            for (int i = 0; i < n; i++) begin
              depth--;
              local_words[top - i] = stack_words[depth];
              local_written[top - i] = 1'b1;
            end
          end
        end
        KIND_ZERO: begin
          if (frame_out_of_range(top, n)) r.error_code = ERR_SLOT;
          else begin
            for (int i = 0; i < n; i++) begin
              local_words[top - i] = '0;
              local_written[top - i] = 1'b1;
            end
          end
        end
        KIND_FETCH: begin
          if (depth >= STACK_DEPTH_DEF) r.error_code = ERR_OVER;
          else if (top >= LOCALS_DEPTH_DEF) r.error_code = ERR_SLOT;
          else begin
            r.read_value = local_words[top];
            stack_words[depth] = r.read_value;
            depth++;
          end
        end
        KIND_STORE: begin
          if (depth == 0) r.error_code = ERR_UNDER;
          else if (top >= LOCALS_DEPTH_DEF) r.error_code = ERR_SLOT;
          else begin
            depth--;
            r.read_value = stack_words[depth];
            local_words[top] = r.read_value;
            local_written[top] = 1'b1;
          end
        end
        default: ;
      endcase
      r.depth = DEPTH_OUT_W'(depth);
      results_due.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] read_value,
                               logic [DEPTH_OUT_W-1:0] depth_seen,
                               logic [ERR_W-1:0] error_code);
      slu_result_t want;
      if (results_due.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: value %0d depth %0d err %0d",
                   $realtime, read_value, depth_seen, error_code);
        return;
      end
      want = results_due.pop_front();
      if (want.read_value !== read_value || want.depth !== depth_seen ||
          want.error_code !== error_code) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected value %0d depth %0d err %0d, got %0d %0d %0d",
                   $realtime, want.read_value, want.depth, want.error_code,
                   read_value, depth_seen, error_code);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_kind;
  logic [SLOT_W-1:0]         in_slot;
  logic [COUNT_W-1:0]        in_count;
  logic signed [VALUE_W-1:0] in_push_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [DEPTH_OUT_W-1:0]    out_depth;
  logic [ERR_W-1:0]          out_error_code;

  stack_frame_ledger ledger;
  bit                idle_on = 1'b1;
  bit                hold_out = 1'b0;
  int                sent = 0;
  int                no_progress = 0;

  stack_locals_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_slot        (in_slot),
    .in_count       (in_count),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_depth      (out_depth),
    .out_error_code (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        ledger.apply_request(in_kind, in_slot, in_count, in_push_value);
      if (out_valid && out_ready)
        ledger.check_result(out_read_value, out_depth, out_error_code);
    end
  end

  // Watchdog: ends the run after too many cycles without a handshake.
  initial begin
    while (no_progress < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) no_progress = 0;
      else no_progress++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the falling edge after it is accepted.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                              logic [COUNT_W-1:0] count,
                              logic signed [VALUE_W-1:0] value);
    if (sent >= CALM_FROM) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_slot       <= slot;
    in_count      <= count;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Builds one random request biased by the walk mode; mostly well-formed frames.
  task automatic send_random(walk_mode_t mode);
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] value;
    int unsigned               pick;
    int unsigned               depth;
    int unsigned               cmax;
    int unsigned               lo;
    depth = ledger.depth;
    value = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: value = WORD_MAX;
        1: value = WORD_MIN;
        2: value = '1;
        default: value = '0;
      endcase
    end
    slot = SLOT_W'($urandom);
    count = '0;
    if ($urandom_range(0, 99) < 8) begin
      // Noise: any kind, any slot, any count.
      kind = KIND_W'($urandom_range(0, 7));
      count = COUNT_W'($urandom_range(0, 511));
    end else begin
      pick = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:
          kind = pick < 70 ? KIND_PUSH : pick < 85 ? KIND_FETCH :
                 pick < 90 ? KIND_COPY : pick < 95 ? KIND_ZERO : KIND_POP;
        MODE_DRAIN:
          kind = pick < 40 ? KIND_POP : pick < 60 ? KIND_STORE :
                 pick < 85 ? KIND_COPY : pick < 95 ? KIND_ZERO : KIND_PUSH;
        default:
          kind = pick < 20 ? KIND_PUSH : pick < 35 ? KIND_POP :
                 pick < 50 ? KIND_COPY : pick < 65 ? KIND_ZERO :
                 pick < 82 ? KIND_FETCH : KIND_STORE;
      endcase
      // Frames fit the stack and the slot range; only a few are large.
      if (kind == KIND_COPY || kind == KIND_ZERO) begin
        cmax = (kind == KIND_COPY) ? depth : LOCALS_DEPTH_DEF;
        if ($urandom_range(0, 29) != 0 && cmax > 8) cmax = 8;
        count = COUNT_W'($urandom_range(0, cmax));
        lo = (count == 0) ? 0 : count - 1;
        slot = SLOT_W'($urandom_range(lo, LOCALS_DEPTH_DEF - 1));
      end
    end
    // A fetch that would read a never-written local is turned into a push.
    if (kind == KIND_FETCH && depth < STACK_DEPTH_DEF && !ledger.local_written[slot])
      kind = KIND_PUSH;
    send_request(kind, slot, count, value);
  endtask

  initial begin
    walk_mode_t mode;
    int         phase_len;
    int         tail;
    bit         mid_hold_done;
    ledger        = new;
    mid_hold_done = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_PUSH;
    in_slot       = '0;
    in_count      = '0;
    in_push_value = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: empty stack, zero counts, slot range, extreme words.
    send_request(KIND_POP,   8'd0,   9'd0,   '0);
    send_request(KIND_STORE, 8'd0,   9'd0,   '0);
    send_request(KIND_COPY,  8'd0,   9'd0,   '0);
    send_request(KIND_COPY,  8'd5,   9'd1,   '0);
    send_request(KIND_ZERO,  8'd9,   9'd0,   '0);
    send_request(KIND_ZERO,  8'd3,   9'd5,   '0);
    send_request(KIND_ZERO,  8'd0,   9'd511, '0);
    send_request(KIND_ZERO,  8'd255, 9'd256, '0);
    send_request(KIND_PUSH,  8'd0,   9'd0,   WORD_MAX);
    send_request(KIND_PUSH,  8'd0,   9'd0,   WORD_MIN);
    send_request(KIND_PUSH,  8'd0,   9'd0,   '1);
    send_request(KIND_PUSH,  8'd0,   9'd0,   '0);
    send_request(KIND_COPY,  8'd1,   9'd5,   '0);
    send_request(KIND_COPY,  8'd0,   9'd2,   '0);
    send_request(KIND_COPY,  8'd255, 9'd2,   '0);
    send_request(KIND_FETCH, 8'd255, 9'd0,   '0);
    send_request(KIND_FETCH, 8'd254, 9'd0,   '0);
    send_request(KIND_STORE, 8'd128, 9'd0,   '0);
    send_request(KIND_FETCH, 8'd128, 9'd0,   '0);
    send_request(KIND_SPARE_A, 8'd255, 9'd511, '1);
    send_request(KIND_SPARE_B, 8'd0,   9'd0,   WORD_MIN);
    send_request(KIND_COPY,  8'd200, 9'd511, '0);
    send_request(KIND_POP,   8'd0,   9'd0,   '0);
    send_request(KIND_POP,   8'd0,   9'd0,   '0);

    // Random walks; the receiver holds off twice so the unit backs up.
    hold_out = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      mode = walk_mode_t'($urandom_range(0, 2));
      idle_on = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      phase_len = (mode == MODE_FILL) ? 600 : (mode == MODE_DRAIN) ? 400 : 60;
      tail = 0;
      for (int step = 0; step < phase_len && tail < 4 && sent < RANDOM_ITEMS; step++) begin
        if (!mid_hold_done && sent >= RANDOM_ITEMS / 2) begin
          mid_hold_done = 1'b1;
          hold_out = 1'b1;
        end
        send_random(mode);
        // A few refused requests once the walk reaches full or empty.
        if ((mode == MODE_FILL && ledger.depth == STACK_DEPTH_DEF) ||
            (mode == MODE_DRAIN && ledger.depth == 0))
          tail++;
      end
    end
    in_valid <= 1'b0;

    // Wait for the last results, then for any stray ones.
    while (ledger.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
src/slu_pkg.sv
src/slu_ram.sv
src/stack_locals_unit.sv
bench/tb.sv
